FILE: src/arpa_pkg.sv
// shared constants and types for the aligned range page allocator
// used by arpa_mod_unit, arpa_range_mem and aligned_range_page_allocator_top
`timescale 1ns / 1ps
`default_nettype none
package arpa_pkg;
   localparam int MAX_RANGES = 64;
   localparam int ADDR_BITS  = 48;
   localparam int IDX_BITS   = $clog2(MAX_RANGES);
   localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);
   localparam int STEP_BITS  = $clog2(ADDR_BITS);

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [1:0] {
      ST_GRANTED = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_FULL    = 2'd2,
      ST_ZERO    = 2'd3
   } status_type;

   typedef enum logic {
      REG_REGION_START = 1'b0,
      REG_REGION_LIMIT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic     en;
      idx_type  idx;
      addr_type start;
      addr_type stop;
   } mem_wr_type;
endpackage
`default_nettype wire

FILE: src/arpa_mod_unit.sv
// bit-serial remainder unit, one quotient bit per cycle
// depends on arpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module arpa_mod_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire arpa_pkg::addr_type dividend,
   input  wire arpa_pkg::addr_type divisor,
   output logic                   done,
   output arpa_pkg::addr_type     remainder
);
   import arpa_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [ADDR_BITS:0]     rem_ff, rem_in;
   addr_type               num_ff, num_in;
   addr_type               div_ff, div_in;
   logic [ADDR_BITS:0]     trial;

   always_comb begin
      trial   = {rem_ff[ADDR_BITS-1:0], num_ff[ADDR_BITS-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(ADDR_BITS - 1);
         rem_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         num_in = {num_ff[ADDR_BITS-2:0], 1'b0};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[ADDR_BITS-1:0];
endmodule
`default_nettype wire

FILE: src/arpa_range_mem.sv
// free range table: one write port, one registered read port
// head entry is taken from the region registers until first written; depends on arpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module arpa_range_mem (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                init_en,
   input  wire arpa_pkg::addr_type  init_start,
   input  wire arpa_pkg::addr_type  init_stop,
   input  wire arpa_pkg::mem_wr_type wr,
   input  wire arpa_pkg::idx_type   rd_idx,
   output arpa_pkg::addr_type       rd_start,
   output arpa_pkg::addr_type       rd_stop
);
   import arpa_pkg::*;

   logic [2*ADDR_BITS-1:0] mem [MAX_RANGES];
   logic [2*ADDR_BITS-1:0] rd_data_ff;
   logic                   head_valid_ff;
   logic                   head_sel_ff;
   addr_type               head_start_ff;
   addr_type               head_stop_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= {wr.start, wr.stop};
      end
      rd_data_ff <= mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b1;
         head_start_ff <= '0;
         head_stop_ff  <= '0;
      end else if (init_en) begin
         head_valid_ff <= 1'b1;
         head_start_ff <= init_start;
         head_stop_ff  <= init_stop;
      end else if (wr.en && wr.idx == '0) begin
         head_valid_ff <= 1'b0;
      end
      head_sel_ff <= head_valid_ff && rd_idx == '0;
   end

   assign rd_start = head_sel_ff ? head_start_ff : rd_data_ff[2*ADDR_BITS-1:ADDR_BITS];
   assign rd_stop  = head_sel_ff ? head_stop_ff  : rd_data_ff[ADDR_BITS-1:0];
endmodule
`default_nettype wire

FILE: src/aligned_range_page_allocator_top.sv
// aligned first-fit range allocator, top level with scan sequencer
// depends on arpa_pkg, arpa_mod_unit, arpa_range_mem
//
// channel | dir | signals                                 | word
// req     | in  | req_tvalid req_tready req_tdata         | request_size
// rsp     | out | rsp_tvalid rsp_tready rsp_tdata rsp_tuser | granted_address, status
// csr     | in  | csr_valid csr_ready csr_index csr_data  | region register write
//
// a too small range passes S_RD and S_CHK, one that needs the remainder adds S_MOD and S_FIX
// placing adds S_PLACE, a split S_INS_A and S_INS_B, each entry moved a read and a write state
// one request at a time; req_tready is high only while the sequencer is idle and no csr write
// synchronous reset restores an empty region and a one-range table at once
// a stalled rsp holds the finished word and the next request waits in its final step
`timescale 1ns / 1ps
`default_nettype none
module aligned_range_page_allocator_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [47:0]               req_tdata,   // request_size
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [47:0]                    rsp_tdata,   // granted_address
   output logic [1:0]                     rsp_tuser,   // status
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [47:0]               csr_data
);
   import arpa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_CHK, S_MOD, S_FIX, S_PLACE, S_SH_RD, S_SH_WR,
      S_INS_A, S_INS_B, S_DEL_RD, S_DEL_WR, S_DONE
   } state_type;

   state_type  state_ff;
   addr_type   region_start_ff, region_limit_ff;
   cnt_type    count_ff;
   cnt_type    i_ff;
   cnt_type    j_ff;
   addr_type   size_ff, lo_ff, hi_ff, base0_ff, base_ff, end_ff;
   addr_type   res_addr_ff;
   status_type res_status_ff;
   addr_type   rsp_addr_ff;
   status_type rsp_status_ff;
   logic       rsp_valid_ff;
   logic       mod_start_ff;

   mem_wr_type wr;
   idx_type    rd_idx;
   addr_type   rd_start, rd_stop;
   logic       mod_done;
   addr_type   mod_rem;
   logic       csr_fire, req_fire, init_en;
   logic       chk_fit;
   cnt_type    i_next;

   assign req_tready = state_ff == S_IDLE && !csr_valid;
   assign csr_ready  = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_fire   = csr_valid && csr_ready;
   assign init_en    = csr_fire;
   assign i_next     = i_ff + 1'b1;
   assign chk_fit    = !(rd_stop <= rd_start || rd_stop - rd_start < size_ff);

   arpa_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start_ff),
      .dividend  (base0_ff),
      .divisor   (size_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   arpa_range_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .init_en    (init_en),
      .init_start (csr_index == REG_REGION_START ? csr_data : region_start_ff),
      .init_stop  (csr_index == REG_REGION_LIMIT ? csr_data : region_limit_ff),
      .wr         (wr),
      .rd_idx     (rd_idx),
      .rd_start   (rd_start),
      .rd_stop    (rd_stop)
   );

   always_comb begin
      rd_idx   = i_ff[IDX_BITS-1:0];
      wr       = '0;
      unique case (state_ff)
         S_SH_RD:  rd_idx = IDX_BITS'(j_ff - 1'b1);
         S_DEL_RD: rd_idx = IDX_BITS'(j_ff + 1'b1);
         S_SH_WR, S_DEL_WR: begin
            wr.en    = 1'b1;
            wr.idx   = j_ff[IDX_BITS-1:0];
            wr.start = rd_start;
            wr.stop  = rd_stop;
         end
         S_INS_A: begin
            wr.en    = 1'b1;
            wr.idx   = i_ff[IDX_BITS-1:0];
            wr.start = lo_ff;
            wr.stop  = base_ff;
         end
         S_INS_B: begin
            wr.en    = 1'b1;
            wr.idx   = i_next[IDX_BITS-1:0];
            wr.start = end_ff;
            wr.stop  = hi_ff;
         end
         S_PLACE: begin
            wr.idx = i_ff[IDX_BITS-1:0];
            if (base_ff >= lo_ff && base_ff > lo_ff && end_ff >= hi_ff) begin
               wr.en    = 1'b1;
               wr.start = lo_ff;
               wr.stop  = base_ff;
            end else if (base_ff == lo_ff && end_ff < hi_ff) begin
               wr.en    = 1'b1;
               wr.start = end_ff;
               wr.stop  = hi_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         region_start_ff <= '0;
         region_limit_ff <= '0;
         count_ff        <= CNT_BITS'(1);
         rsp_valid_ff    <= 1'b0;
         mod_start_ff    <= 1'b0;
      end else begin
         mod_start_ff <= state_ff == S_CHK && chk_fit;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_fire) begin
            count_ff <= CNT_BITS'(1);
            if (csr_index == REG_REGION_START) begin
               region_start_ff <= csr_data;
            end else begin
               region_limit_ff <= csr_data;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  size_ff <= req_tdata;
                  i_ff    <= '0;
                  if (req_tdata == '0) begin
                     res_addr_ff   <= '0;
                     res_status_ff <= ST_ZERO;
                     state_ff      <= S_DONE;
                  end else if (count_ff == '0) begin
                     res_addr_ff   <= '0;
                     res_status_ff <= ST_NOFIT;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_CHK;
            S_CHK: begin
               lo_ff    <= rd_start;
               hi_ff    <= rd_stop;
               base0_ff <= rd_stop - size_ff;
               if (!chk_fit) begin
                  i_ff <= i_next;
                  if (i_next >= count_ff) begin
                     res_addr_ff   <= '0;
                     res_status_ff <= ST_NOFIT;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end else begin
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  base_ff  <= base0_ff - mod_rem;
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               end_ff <= base_ff + size_ff;
               if (base_ff < lo_ff) begin
                  i_ff <= i_next;
                  if (i_next >= count_ff) begin
                     res_addr_ff   <= '0;
                     res_status_ff <= ST_NOFIT;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_RD;
                  end
               end else begin
                  state_ff <= S_PLACE;
               end
            end
            S_PLACE: begin
               if (base_ff > lo_ff && end_ff < hi_ff &&
                   count_ff >= CNT_BITS'(MAX_RANGES)) begin
                  res_addr_ff   <= '0;
                  res_status_ff <= ST_FULL;
                  state_ff      <= S_DONE;
               end else begin
                  res_addr_ff   <= base_ff;
                  res_status_ff <= ST_GRANTED;
                  if (base_ff > lo_ff && end_ff < hi_ff) begin
                     j_ff     <= count_ff;
                     state_ff <= (count_ff > i_next) ? S_SH_RD : S_INS_A;
                  end else if (base_ff > lo_ff || end_ff < hi_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     j_ff <= i_ff;
                     if (i_next < count_ff) begin
                        state_ff <= S_DEL_RD;
                     end else begin
                        count_ff <= count_ff - 1'b1;
                        state_ff <= S_DONE;
                     end
                  end
               end
            end
            S_SH_RD: state_ff <= S_SH_WR;
            S_SH_WR: begin
               j_ff     <= j_ff - 1'b1;
               state_ff <= (j_ff - 1'b1 > i_next) ? S_SH_RD : S_INS_A;
            end
            S_INS_A: state_ff <= S_INS_B;
            S_INS_B: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_DONE;
            end
            S_DEL_RD: state_ff <= S_DEL_WR;
            S_DEL_WR: begin
               j_ff <= j_ff + 1'b1;
               if (j_ff + CNT_BITS'(2) < count_ff) begin
                  state_ff <= S_DEL_RD;
               end else begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_RANGES))
      else $error("range count above table size");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_GRANTED |-> rsp_tdata == '0)
      else $error("failed request carries an address");

   a_csr_reinit: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> count_ff == CNT_BITS'(1))
      else $error("table not reset by region write");

   a_mod_from_chk: assert property (@(posedge clock) disable iff (reset)
      mod_start_ff |-> state_ff == S_MOD && $past(state_ff) == S_CHK)
      else $error("remainder unit started outside range check");
endmodule
`default_nettype wire

FILE: tb/tb_aligned_range_page_allocator_top.sv
// testbench for aligned_range_page_allocator_top: directed and random size requests
// checked against a first-fit free range predictor kept in a small scoreboard class
// depends on arpa_pkg and the allocator rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_aligned_range_page_allocator_top;
   import arpa_pkg::*;

   localparam int WATCH_LIMIT = 40000;
   localparam addr_type ADDR_MAX = '1;

   typedef struct {
      addr_type   addr;
      status_type status;
   } grant_type;

   class range_scoreboard;
      addr_type   region_lo, region_hi;
      addr_type   free_lo[MAX_RANGES];
      addr_type   free_hi[MAX_RANGES];
      int         free_cnt;
      grant_type  pending_q[$];
      int         errors, accepted, seen;
      int         by_status[4];

      function new();
         region_lo = '0;
         region_hi = '0;
         rebuild();
      endfunction

      function void rebuild();
         free_lo[0] = region_lo;
         free_hi[0] = region_hi;
         free_cnt = 1;
      endfunction

      function void set_region(reg_index_type idx, addr_type val);
         if (idx == REG_REGION_START) region_lo = val;
         else region_hi = val;
         rebuild();
      endfunction

      function void push_grant(addr_type a, status_type s);
         grant_type g;
         g.addr = a;
         g.status = s;
         pending_q.push_back(g);
         by_status[s]++;
      endfunction

      // first fit, highest aligned block in the chosen range
      function void note(addr_type size);
         addr_type lo, hi, base, blk_end;
         bit keep_l, keep_r;
         accepted++;
         if (size == '0) begin
            push_grant('0, ST_ZERO);
            return;
         end
         for (int i = 0; i < free_cnt; i++) begin
            lo = free_lo[i];
            hi = free_hi[i];
            if (hi <= lo || hi - lo < size) continue;
            base = hi - size;
            base = base - (base % size);
            if (base < lo) continue;
            blk_end = base + size;
            keep_l = base > lo;
            keep_r = blk_end < hi;
            if (keep_l && keep_r) begin
               if (free_cnt >= MAX_RANGES) begin
                  push_grant('0, ST_FULL);
                  return;
               end
               for (int j = free_cnt; j > i + 1; j--) begin
                  free_lo[j] = free_lo[j-1];
                  free_hi[j] = free_hi[j-1];
               end
               free_hi[i] = base;
               free_lo[i+1] = blk_end;
               free_hi[i+1] = hi;
               free_cnt++;
            end else if (keep_l) begin
               free_hi[i] = base;
            end else if (keep_r) begin
               free_lo[i] = blk_end;
            end else begin
               for (int j = i; j + 1 < free_cnt; j++) begin
                  free_lo[j] = free_lo[j+1];
                  free_hi[j] = free_hi[j+1];
               end
               free_cnt--;
            end
            push_grant(base, ST_GRANTED);
            return;
         end
         push_grant('0, ST_NOFIT);
      endfunction

      function void check(addr_type a, logic [1:0] s);
         grant_type g;
         seen++;
         if (pending_q.size() == 0) begin
            $error("unexpected word: granted_address %h status %0d", a, s);
            errors++;
            return;
         end
         g = pending_q.pop_front();
         if (a !== g.addr) begin
            $error("granted_address: expected %h actual %h", g.addr, a);
            errors++;
         end
         if (s !== g.status) begin
            $error("status: expected %0d actual %0d", g.status, s);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_tvalid = 0;
   logic       req_tready;
   addr_type   req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 0;
   addr_type   rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       csr_valid = 0;
   logic       csr_ready;
   logic       csr_index = 0;
   addr_type   csr_data = '0;

   range_scoreboard sb = new();
   int burst_left = 0;
   int phases = 0;
   int idle_cycles = 0;
   bit held_off = 0;

   aligned_range_page_allocator_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver stall pattern with one long hold-off
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 200 == 0) mode = $urandom_range(0, 2);
         if (!held_off && sb.accepted >= 400) begin
            held_off = 1;
            rsp_tready <= 0;
            repeat (600) @(negedge clock);
         end else begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= (cyc % 5) != 0;
            endcase
         end
      end
   end

   task automatic push(input addr_type size);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata <= size;
      do @(posedge clock); while (!req_tready);
      sb.note(size);
      burst_left--;
   endtask

   task automatic write_reg(input reg_index_type idx, input addr_type val);
      @(negedge clock);
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_region(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      burst_left = 0;
   endtask

   task automatic set_region(input addr_type lo, input addr_type hi);
      if ($urandom_range(0, 1)) begin
         write_reg(REG_REGION_START, lo);
         write_reg(REG_REGION_LIMIT, hi);
      end else begin
         write_reg(REG_REGION_LIMIT, hi);
         write_reg(REG_REGION_START, lo);
      end
      phases++;
   endtask

   function automatic addr_type rand48();
      return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
   endfunction

   function automatic addr_type pick_size(input int span);
      case ($urandom_range(0, 15))
         0: return '0;
         1: return rand48();
         2: return addr_type'(1) << $urandom_range(0, 47);
         3: return ADDR_MAX;
         default: return $urandom_range(1, (span < 8) ? 2 : span / 4);
      endcase
   endfunction

   initial begin
      addr_type lo, hi;
      int span, n, kind;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // empty region after reset
      push('0);
      push(48'd1);
      push(ADDR_MAX);
      // block at address zero, then the table empties
      set_region('0, 48'd4096);
      push(48'd4096);
      push(48'd1);
      // whole address space
      set_region('0, ADDR_MAX);
      push(addr_type'(1) << 47);
      push(ADDR_MAX);
      push(48'd3);
      push(48'h5555_5555_5555);
      push(48'hAAAA_AAAA_AAAA);
      // inverted and empty regions
      set_region(48'd1000, 48'd10);
      push(48'd1);
      set_region(ADDR_MAX, ADDR_MAX);
      push(48'd1);
      set_region(48'd5, 48'd5);
      push(48'd1);
      push('0);

      // random phases, the first one splits until the table is full
      kind = 6;
      while (sb.accepted < 1720) begin
         case (kind)
            0: begin lo = $urandom_range(0, 1 << 20); span = $urandom_range(16, 4096); end
            1: begin lo = '0; span = $urandom_range(1 << 10, 1 << 20); end
            2: begin lo = rand48(); span = $urandom_range(1, 1 << 16); end
            3: begin lo = $urandom_range(100, 100000); span = -$urandom_range(0, 50); end
            4: begin lo = '0; span = 0; end
            5: begin lo = ADDR_MAX - $urandom_range(0, 4096); span = 0; end
            default: begin lo = $urandom_range(0, 255); span = 1 << 20; end
         endcase
         if (kind == 4) hi = ADDR_MAX;
         else if (kind == 5) hi = ADDR_MAX;
         else hi = lo + addr_type'(signed'(span));
         if (kind != 3 && hi < lo) hi = ADDR_MAX;
         set_region(lo, hi);
         n = (kind == 6) ? $urandom_range(70, 110) : $urandom_range(10, 60);
         for (int k = 0; k < n; k++) begin
            if (kind == 6 && $urandom_range(0, 7) != 0)
               push($urandom_range(3, 1000) | 1);
            else if (kind == 4 || kind == 5)
               push(($urandom_range(0, 3) == 0) ? pick_size(1 << 20) : rand48());
            else
               push(pick_size((span > 0) ? span : 64));
         end
         kind = ($urandom_range(0, 3) == 0) ? 6 : $urandom_range(0, 5);
      end

      @(negedge clock);
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("covered %0d requests over %0d region settings, %0d words checked",
               sb.accepted, phases, sb.seen);
      $display("granted %0d, no fit %0d, table full %0d, zero size %0d",
               sb.by_status[ST_GRANTED], sb.by_status[ST_NOFIT],
               sb.by_status[ST_FULL], sb.by_status[ST_ZERO]);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
src/arpa_pkg.sv
src/arpa_mod_unit.sv
src/arpa_range_mem.sv
src/aligned_range_page_allocator_top.sv
tb/tb_aligned_range_page_allocator_top.sv
